FILE: sv/ptu_pkg.sv
// ----------------------------------------------------------------------------
// ptu_pkg
// Shared types, codes and arithmetic helpers of the particle table update.
// ----------------------------------------------------------------------------
package ptu_pkg;

    localparam int NumSlots = 32;
    localparam int SlotW    = $clog2(NumSlots);

    localparam int CfgIdxW  = 1;
    localparam int CfgW     = 17;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] CFG_DUST_LIFE = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_DAMPING   = 1'd1;

    localparam logic [CfgW-1:0] DustLifeReset = 17'd19661;
    localparam logic [CfgW-1:0] DampingReset  = 17'd62259;

    // command codes (tuser of the input word)
    localparam logic CMD_SPAWN = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // status codes (tuser of the output word)
    localparam logic [1:0] ST_SPAWNED = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_REPORT  = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // velocity at spawn: floor(d * 65536 / 500) - 6554, with d below 100.
    // 65536/500 is taken as VelRecip / 2^24, rounded up; the excess stays far
    // below the 1/500 spacing of the true fractions, so the floor is exact.
    localparam logic [31:0] VelRecip  = 32'd2199023256;
    localparam int          VelShift  = 24;
    localparam logic [31:0] VelOffset = 32'd6554;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_LIFE,
        S_PX,
        S_PY,
        S_VX,
        S_WB,
        S_END
    } t_state;

    function automatic logic [31:0] spawn_vel(input logic [6:0] r);
        logic [6:0]  d;
        logic [38:0] p;
        begin
            d = (r >= 7'd100) ? (r - 7'd100) : r;
            p = {32'd0, d} * {7'd0, VelRecip};
            spawn_vel = {18'd0, p[VelShift +: 14]} - VelOffset;
        end
    endfunction

    // clamp a 34-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -34'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

FILE: sv/particle_table_update.sv
// ----------------------------------------------------------------------------
// particle_table_update
// Table of 32 particles in signed Q16.16, spawned and advanced by stream words.
// ----------------------------------------------------------------------------
// Input words carry a command in s_axis_tuser: spawn places a dust particle in
// the first free slot and answers with one word (slot or table full); tick
// ages every live particle by delta_t, frees the expired ones, moves and damps
// the rest, and answers with one report word per survivor in slot order, or
// one empty word. tlast marks the final word of each answer.
// The block takes one input word at a time; s_axis_tready is low until the
// whole answer sits in the output register. One signed 32x18 multiplier is
// shared for the four products of each survivor.
// Spawn scans the slots in order up to the first free one. Tick reads each
// slot in turn: a dead slot is skipped, an expiring one is freed after its
// life check, and a survivor passes through the PX, PY, VX and WB states.
// Reset clears all live flags and restores dust_life and damping; slot data
// is not cleared. When m_axis_tready is low the sequencer holds before each
// new word until the output register frees up; nothing is dropped.
// Configuration writes are taken at any time but are meant for idle periods.
// ----------------------------------------------------------------------------
module particle_table_update (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] spawn_x, [63:32] spawn_y, [70:64] rand_x, [77:71] rand_y,
    // [94:78] delta_t, [95] zero
    input  logic [95:0] s_axis_tdata,
    // [0] cmd
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] slot, [36:5] pos_x, [68:37] pos_y, [71:69] zero
    output logic [71:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam logic [ptu_pkg::SlotW-1:0] LastSlot = ptu_pkg::SlotW'(ptu_pkg::NumSlots - 1);

    ptu_pkg::t_state r_state, n_state;

    // configuration
    logic [16:0] r_dust_life;
    logic [16:0] r_damping;

    // latched input word
    logic signed [31:0] r_in_x;
    logic signed [31:0] r_in_y;
    logic [6:0]        r_rand_x;
    logic [6:0]        r_rand_y;
    logic [16:0]       r_dt;

    logic [ptu_pkg::SlotW-1:0] r_slot;
    logic [ptu_pkg::NumSlots-1:0] r_alive;

    // slot storage
    logic signed [31:0] r_mem_life [ptu_pkg::NumSlots];
    logic signed [31:0] r_mem_px   [ptu_pkg::NumSlots];
    logic signed [31:0] r_mem_py   [ptu_pkg::NumSlots];
    logic signed [31:0] r_mem_vx   [ptu_pkg::NumSlots];
    logic signed [31:0] r_mem_vy   [ptu_pkg::NumSlots];

    logic signed [31:0] r_rd_life, r_rd_px, r_rd_py, r_rd_vx, r_rd_vy;

    // per-slot working values
    logic signed [31:0] r_new_life, r_new_px, r_new_py, r_new_vx;
    logic signed [48:0] r_prod;

    // one report held back until it is known whether it is the final one
    logic                      r_pend_valid;
    logic [ptu_pkg::SlotW-1:0] r_pend_slot;
    logic signed [31:0]        r_pend_px, r_pend_py;

    // output register
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic [ptu_pkg::SlotW-1:0] r_out_slot;
    logic signed [31:0]        r_out_px, r_out_py;
    logic                      r_out_last;

    // control
    logic               c_accept;
    logic               c_out_free;
    logic               c_slot_free;
    logic               c_is_last;
    logic               c_life_dead;
    logic signed [32:0] c_life;
    logic               c_spawn_wr;
    logic               c_tick_wr;
    logic               c_slot_inc;
    logic               c_alive_clr;
    logic               c_mul_en;
    logic signed [31:0] c_mul_a;
    logic [16:0]        c_mul_b;
    logic               c_emit;
    logic [1:0]         c_emit_status;
    logic [ptu_pkg::SlotW-1:0] c_emit_slot;
    logic signed [31:0] c_emit_px, c_emit_py;
    logic               c_emit_last;

    logic signed [49:0] c_mul_full;
    logic signed [32:0] c_step;
    logic signed [32:0] c_damp_q;
    logic signed [31:0] c_new_vy;
    logic [31:0]        c_spawn_vx, c_spawn_vy;

    assign c_out_free  = !r_out_valid || m_axis_tready;
    assign c_slot_free = !r_alive[r_slot];
    assign c_is_last   = (r_slot == LastSlot);
    assign c_life      = {r_rd_life[31], r_rd_life} - $signed({16'd0, r_dt});
    assign c_life_dead = (c_life <= 33'sd0);

    // shared multiplier: signed 32 x unsigned 17
    assign c_mul_full = c_mul_a * $signed({1'b0, c_mul_b});

    // floor(vel * dt / 65536)
    assign c_step   = r_prod[48:16];
    // vel * damping / 65536, truncated toward zero
    assign c_damp_q = (r_prod[48] && (r_prod[15:0] != 16'd0)) ? (r_prod[48:16] + 33'sd1)
                                                               : r_prod[48:16];
    assign c_new_vy = ptu_pkg::sat32({c_damp_q[32], c_damp_q});

    assign c_spawn_vx = ptu_pkg::spawn_vel(r_rand_x);
    assign c_spawn_vy = ptu_pkg::spawn_vel(r_rand_y);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptu_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser[0] == ptu_pkg::CMD_TICK) ? ptu_pkg::S_RD
                                                                     : ptu_pkg::S_SCAN;
                end
            end
            ptu_pkg::S_SCAN: begin
                if ((c_slot_free || c_is_last) && c_out_free) begin
                    n_state = ptu_pkg::S_IDLE;
                end
            end
            ptu_pkg::S_RD: begin
                if (r_alive[r_slot]) begin
                    n_state = ptu_pkg::S_LIFE;
                end else if (c_is_last) begin
                    n_state = ptu_pkg::S_END;
                end
            end
            ptu_pkg::S_LIFE: begin
                if (!c_life_dead) begin
                    n_state = ptu_pkg::S_PX;
                end else if (c_is_last) begin
                    n_state = ptu_pkg::S_END;
                end else begin
                    n_state = ptu_pkg::S_RD;
                end
            end
            ptu_pkg::S_PX: n_state = ptu_pkg::S_PY;
            ptu_pkg::S_PY: n_state = ptu_pkg::S_VX;
            ptu_pkg::S_VX: n_state = ptu_pkg::S_WB;
            ptu_pkg::S_WB: begin
                if (!r_pend_valid || c_out_free) begin
                    n_state = c_is_last ? ptu_pkg::S_END : ptu_pkg::S_RD;
                end
            end
            ptu_pkg::S_END: begin
                if (c_out_free) begin
                    n_state = ptu_pkg::S_IDLE;
                end
            end
            default: n_state = ptu_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        c_accept      = 1'b0;
        c_spawn_wr    = 1'b0;
        c_tick_wr     = 1'b0;
        c_slot_inc    = 1'b0;
        c_alive_clr   = 1'b0;
        c_mul_en      = 1'b0;
        c_mul_a       = r_rd_vx;
        c_mul_b       = r_dt;
        c_emit        = 1'b0;
        c_emit_status = ptu_pkg::ST_REPORT;
        c_emit_slot   = r_pend_slot;
        c_emit_px     = r_pend_px;
        c_emit_py     = r_pend_py;
        c_emit_last   = 1'b0;
        case (r_state)
            ptu_pkg::S_IDLE: begin
                c_accept = s_axis_tvalid;
            end
            ptu_pkg::S_SCAN: begin
                if (c_slot_free) begin
                    if (c_out_free) begin
                        c_spawn_wr    = 1'b1;
                        c_emit        = 1'b1;
                        c_emit_status = ptu_pkg::ST_SPAWNED;
                        c_emit_slot   = r_slot;
                        c_emit_px     = r_in_x;
                        c_emit_py     = r_in_y;
                        c_emit_last   = 1'b1;
                    end
                end else if (c_is_last) begin
                    if (c_out_free) begin
                        c_emit        = 1'b1;
                        c_emit_status = ptu_pkg::ST_FULL;
                        c_emit_slot   = '0;
                        c_emit_px     = '0;
                        c_emit_py     = '0;
                        c_emit_last   = 1'b1;
                    end
                end else begin
                    c_slot_inc = 1'b1;
                end
            end
            ptu_pkg::S_RD: begin
                c_slot_inc = !r_alive[r_slot] && !c_is_last;
            end
            ptu_pkg::S_LIFE: begin
                c_mul_en = 1'b1;
                if (c_life_dead) begin
                    c_alive_clr = 1'b1;
                    c_slot_inc  = !c_is_last;
                end
            end
            ptu_pkg::S_PX: begin
                c_mul_en = 1'b1;
                c_mul_a  = r_rd_vy;
            end
            ptu_pkg::S_PY: begin
                c_mul_en = 1'b1;
                c_mul_b  = r_damping;
            end
            ptu_pkg::S_VX: begin
                c_mul_en = 1'b1;
                c_mul_a  = r_rd_vy;
                c_mul_b  = r_damping;
            end
            ptu_pkg::S_WB: begin
                if (!r_pend_valid || c_out_free) begin
                    c_tick_wr  = 1'b1;
                    c_emit     = r_pend_valid;
                    c_slot_inc = !c_is_last;
                end
            end
            ptu_pkg::S_END: begin
                if (c_out_free) begin
                    c_emit      = 1'b1;
                    c_emit_last = 1'b1;
                    if (!r_pend_valid) begin
                        c_emit_status = ptu_pkg::ST_EMPTY;
                        c_emit_slot   = '0;
                        c_emit_px     = '0;
                        c_emit_py     = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptu_pkg::S_IDLE;
            r_alive      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot       <= '0;
            r_dust_life  <= ptu_pkg::DustLifeReset;
            r_damping    <= ptu_pkg::DampingReset;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ptu_pkg::CFG_DUST_LIFE: r_dust_life <= i_cfg_data;
                    ptu_pkg::CFG_DAMPING:   r_damping   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (c_accept) begin
                r_slot       <= '0;
                r_pend_valid <= 1'b0;
            end else if (c_slot_inc) begin
                r_slot <= r_slot + 1'b1;
            end
            if (c_spawn_wr) begin
                r_alive[r_slot] <= 1'b1;
            end else if (c_alive_clr) begin
                r_alive[r_slot] <= 1'b0;
            end
            if (c_tick_wr) begin
                r_pend_valid <= 1'b1;
            end
            if (c_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // slot storage, registered read at the current slot
    always_ff @(posedge i_clk) begin
        if (c_spawn_wr) begin
            r_mem_life[r_slot] <= {15'd0, r_dust_life};
            r_mem_px[r_slot]   <= r_in_x;
            r_mem_py[r_slot]   <= r_in_y;
            r_mem_vx[r_slot]   <= c_spawn_vx;
            r_mem_vy[r_slot]   <= c_spawn_vy;
        end else if (c_tick_wr) begin
            r_mem_life[r_slot] <= r_new_life;
            r_mem_px[r_slot]   <= r_new_px;
            r_mem_py[r_slot]   <= r_new_py;
            r_mem_vx[r_slot]   <= r_new_vx;
            r_mem_vy[r_slot]   <= c_new_vy;
        end
        r_rd_life <= r_mem_life[r_slot];
        r_rd_px   <= r_mem_px[r_slot];
        r_rd_py   <= r_mem_py[r_slot];
        r_rd_vx   <= r_mem_vx[r_slot];
        r_rd_vy   <= r_mem_vy[r_slot];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_in_x   <= s_axis_tdata[31:0];
            r_in_y   <= s_axis_tdata[63:32];
            r_rand_x <= s_axis_tdata[70:64];
            r_rand_y <= s_axis_tdata[77:71];
            r_dt     <= s_axis_tdata[94:78];
        end
        if (c_mul_en) begin
            r_prod <= c_mul_full[48:0];
        end
        if (r_state == ptu_pkg::S_LIFE) begin
            r_new_life <= c_life[31:0];
        end
        if (r_state == ptu_pkg::S_PX) begin
            r_new_px <= ptu_pkg::sat32({{2{r_rd_px[31]}}, r_rd_px} + {c_step[32], c_step});
        end
        if (r_state == ptu_pkg::S_PY) begin
            r_new_py <= ptu_pkg::sat32({{2{r_rd_py[31]}}, r_rd_py} + {c_step[32], c_step});
        end
        if (r_state == ptu_pkg::S_VX) begin
            r_new_vx <= ptu_pkg::sat32({c_damp_q[32], c_damp_q});
        end
        if (c_tick_wr) begin
            r_pend_slot <= r_slot;
            r_pend_px   <= r_new_px;
            r_pend_py   <= r_new_py;
        end
        if (c_emit) begin
            r_out_status <= c_emit_status;
            r_out_slot   <= c_emit_slot;
            r_out_px     <= c_emit_px;
            r_out_py     <= c_emit_py;
            r_out_last   <= c_emit_last;
        end
    end

    assign s_axis_tready = (r_state == ptu_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_py, r_out_px, r_out_slot};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: dv/tb_particle_table_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_table_update
// Self-checking bench for the particle table: spawn and tick words in, slot
// and particle reports out, compared in order against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_particle_table_update;

    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] x;
        logic [31:0] y;
        logic [6:0]  rx;
        logic [6:0]  ry;
        logic [16:0] dt;
    } t_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic        last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    particle_table_update uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // particle table copy
    logic        slot_alive [ptu_pkg::NumSlots];
    int          life_left  [ptu_pkg::NumSlots];
    int          pos_x_tab  [ptu_pkg::NumSlots];
    int          pos_y_tab  [ptu_pkg::NumSlots];
    int          vel_x_tab  [ptu_pkg::NumSlots];
    int          vel_y_tab  [ptu_pkg::NumSlots];
    logic [16:0] dust_life_cfg;
    logic [16:0] damping_cfg;

    t_word   pending_words[$];
    t_answer answer_q[$];
    t_answer want;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      fail_cnt;
    int      word_cnt;
    int      cycle_cnt;

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic int dust_velocity(input logic [6:0] r);
        longint d;
        d = longint'(r) % 100;
        return int'(d * 65536 / 500 - 6554);
    endfunction

    function automatic t_word make_word(input logic cmd, input logic [31:0] x,
                                        input logic [31:0] y, input logic [6:0] rx,
                                        input logic [6:0] ry, input logic [16:0] dt);
        t_word w;
        w.cmd = cmd;
        w.x   = x;
        w.y   = y;
        w.rx  = rx;
        w.ry  = ry;
        w.dt  = dt;
        return w;
    endfunction

    // spawn into the first free slot, or age every live slot and move and damp the survivors
    task automatic advance_table(input t_word w);
        longint  dt;
        longint  life;
        int      n;
        bit      placed;
        t_answer a;
        a = '0;
        a.last = 1'b1;
        if (w.cmd == ptu_pkg::CMD_SPAWN) begin
            placed = 1'b0;
            a.status = ptu_pkg::ST_FULL;
            for (int i = 0; i < ptu_pkg::NumSlots && !placed; i++) begin
                if (!slot_alive[i]) begin
                    slot_alive[i] = 1'b1;
                    life_left[i]  = int'(dust_life_cfg);
                    pos_x_tab[i]  = w.x;
                    pos_y_tab[i]  = w.y;
                    vel_x_tab[i]  = dust_velocity(w.rx);
                    vel_y_tab[i]  = dust_velocity(w.ry);
                    a.status = ptu_pkg::ST_SPAWNED;
                    a.slot   = 5'(i);
                    a.px     = w.x;
                    a.py     = w.y;
                    placed   = 1'b1;
                end
            end
            answer_q.push_back(a);
        end else begin
            dt = longint'(w.dt);
            n  = 0;
            for (int i = 0; i < ptu_pkg::NumSlots; i++) begin
                if (!slot_alive[i]) continue;
                life = longint'(life_left[i]) - dt;
                if (life <= 0) begin
                    slot_alive[i] = 1'b0;
                    continue;
                end
                life_left[i] = int'(life);
                // arithmetic shift gives the floor of the Q16.16 product
                pos_x_tab[i] = clamp32(longint'(pos_x_tab[i]) +
                                       ((longint'(vel_x_tab[i]) * dt) >>> 16));
                pos_y_tab[i] = clamp32(longint'(pos_y_tab[i]) +
                                       ((longint'(vel_y_tab[i]) * dt) >>> 16));
                // signed divide truncates toward zero
                vel_x_tab[i] = clamp32(longint'(vel_x_tab[i]) *
                                       longint'(damping_cfg) / 64'sd65536);
                vel_y_tab[i] = clamp32(longint'(vel_y_tab[i]) *
                                       longint'(damping_cfg) / 64'sd65536);
                a.status = ptu_pkg::ST_REPORT;
                a.slot   = 5'(i);
                a.px     = pos_x_tab[i];
                a.py     = pos_y_tab[i];
                a.last   = 1'b0;
                answer_q.push_back(a);
                n++;
            end
            if (n == 0) begin
                a.status = ptu_pkg::ST_EMPTY;
                answer_q.push_back(a);
            end else begin
                answer_q[answer_q.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("word %0d %s: got %0h, want %0h",
                                      word_cnt, name, got, exp_val));
        end
    endtask

    // stream driver: hold a word until taken, then pick the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                advance_table(pending_words.pop_front());
            end
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, pending_words[0].dt, pending_words[0].ry,
                                  pending_words[0].rx, pending_words[0].y,
                                  pending_words[0].x};
                s_axis_tuser  <= pending_words[0].cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: status %0d slot %0d",
                                              m_axis_tuser, m_axis_tdata[4:0]));
                end else begin
                    want = answer_q.pop_front();
                    check_field("status", 32'(m_axis_tuser), 32'(want.status));
                    check_field("slot", 32'(m_axis_tdata[4:0]), 32'(want.slot));
                    check_field("pos_x", m_axis_tdata[36:5], want.px);
                    check_field("pos_y", m_axis_tdata[68:37], want.py);
                    check_field("last", 32'(m_axis_tlast), 32'(want.last));
                end
                word_cnt++;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [16:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == ptu_pkg::CFG_DUST_LIFE) begin
            dust_life_cfg = value;
        end else begin
            damping_cfg = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold off until every word is taken and every answer is back
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count, input int spawn_pct, input int dt_max);
        for (int k = 0; k < count; k++) begin
            pending_words.push_back(make_word(
                ($urandom_range(0, 99) < spawn_pct) ? ptu_pkg::CMD_SPAWN : ptu_pkg::CMD_TICK,
                $urandom, $urandom, 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)), 17'($urandom_range(0, dt_max))));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = ptu_pkg::CFG_DUST_LIFE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ptu_pkg::CMD_SPAWN;
        m_axis_tready = 1'b0;
        fail_cnt      = 0;
        word_cnt      = 0;
        cycle_cnt     = 0;
        dust_life_cfg = ptu_pkg::DustLifeReset;
        damping_cfg   = ptu_pkg::DampingReset;
        send_idle_pct = 18;
        recv_idle_pct = 64;
        for (int i = 0; i < ptu_pkg::NumSlots; i++) begin
            slot_alive[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty tick, saturating edges, odd draws, floor on
        // negative motion, then a tick long enough to free everything
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 32'h7fffffff, 32'h80000000,
                                          99, 0, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 32'h80000000, 32'h7fffffff,
                                          0, 99, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 0, 32'hffffffff, 127, 100,
                                          17'h1ffff));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 16384));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 1));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 17'h1ffff));
        wait_idle();

        // zero life: the next tick frees the particle even with zero elapsed time
        write_reg(ptu_pkg::CFG_DUST_LIFE, 17'd0);
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 32'h00012345, 32'hfffe0000,
                                          64, 1, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        wait_idle();

        // shortest life and zero damping
        write_reg(ptu_pkg::CFG_DUST_LIFE, 17'd1);
        write_reg(ptu_pkg::CFG_DAMPING, 17'd0);
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 32'h00010000, 32'h00020000,
                                          64, 1, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_SPAWN, 32'hffff0000, 32'h55555555,
                                          31, 98, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(ptu_pkg::CMD_TICK, 0, 0, 0, 0, 1));
        wait_idle();

        // long life and maximum damping: fill the table, then grow velocities
        write_reg(ptu_pkg::CFG_DUST_LIFE, 17'h1ffff);
        write_reg(ptu_pkg::CFG_DAMPING, 17'h1ffff);
        queue_random(36, 95, 255);
        queue_random(24, 5, 255);
        wait_idle();

        send_idle_pct = 64;
        recv_idle_pct = 18;
        write_reg(ptu_pkg::CFG_DUST_LIFE, 17'($urandom_range(1, 65536)));
        write_reg(ptu_pkg::CFG_DAMPING, 17'($urandom_range(0, 131071)));
        queue_random(18, 50, 131071);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ptu_pkg::CFG_DUST_LIFE, 17'd65536);
        write_reg(ptu_pkg::CFG_DAMPING, 17'd65536);
        queue_random(17, 45, 65536);
        wait_idle();

        repeat (160) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            report_mismatch($sformatf("%0d answers never arrived", answer_q.size()));
        end
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
